// File: hdl/sha256_three_round_precompute_top_macros.svh
// ----------------------------------------------------------------------------
// sha256 three-round precompute assertion macros
// concurrent check wrappers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef SHA256_THREE_ROUND_PRECOMPUTE_TOP_MACROS_SVH
`define SHA256_THREE_ROUND_PRECOMPUTE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SHA3P_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha3p check failed");
`define SHA3P_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha3p check failed");
`else
`define SHA3P_ASSERT_IMPL(lbl, ante, cons)
`define SHA3P_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/sha3p_pkg.sv
// ----------------------------------------------------------------------------
// sha3p_pkg
// types, round constants and round functions for the three-round precompute
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha3p_pkg;

    localparam int unsigned NUM_ROUNDS = 3;

    typedef logic [31:0] word_t;
    typedef logic [1:0]  round_idx_t;

    localparam round_idx_t ROUND_0 = 2'd0;
    localparam round_idx_t ROUND_1 = 2'd1;
    localparam round_idx_t ROUND_2 = 2'd2;

    localparam word_t K_ROUND_0 = 32'h428a2f98;
    localparam word_t K_ROUND_1 = 32'h71374491;
    localparam word_t K_ROUND_2 = 32'hb5c0fbcf;

    typedef struct packed {
        word_t state_a;
        word_t state_b;
        word_t state_c;
        word_t state_d;
        word_t state_e;
        word_t state_f;
        word_t state_g;
        word_t state_h;
        word_t msg_word0;
        word_t msg_word1;
        word_t msg_word2;
    } job_t;

    typedef struct packed {
        word_t a_after_round0;
        word_t a_after_round1;
        word_t a_after_round2;
        word_t e_after_round0;
        word_t e_after_round1;
        word_t e_after_round2;
    } result_t;

    // working variables plus message words and results collected so far
    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        word_t e;
        word_t f;
        word_t g;
        word_t h;
        word_t w0;
        word_t w1;
        word_t w2;
        word_t na0;
        word_t na1;
        word_t na2;
        word_t ne0;
        word_t ne1;
        word_t ne2;
    } work_t;

    function automatic word_t round_k(input round_idx_t idx);
        word_t k;
        case (idx)
            ROUND_0: k = K_ROUND_0;
            ROUND_1: k = K_ROUND_1;
            ROUND_2: k = K_ROUND_2;
            default: k = K_ROUND_0;
        endcase
        return k;
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t choose(input word_t e, input word_t f, input word_t g);
        return g ^ (e & (f ^ g));
    endfunction

    function automatic word_t majority(input word_t a, input word_t b, input word_t c);
        return (a & b) | (c & (a | b));
    endfunction

    function automatic work_t job_to_work(input job_t j);
        work_t w;
        w     = '0;
        w.a   = j.state_a;
        w.b   = j.state_b;
        w.c   = j.state_c;
        w.d   = j.state_d;
        w.e   = j.state_e;
        w.f   = j.state_f;
        w.g   = j.state_g;
        w.h   = j.state_h;
        w.w0  = j.msg_word0;
        w.w1  = j.msg_word1;
        w.w2  = j.msg_word2;
        return w;
    endfunction

    function automatic result_t work_to_result(input work_t w);
        result_t r;
        r.a_after_round0 = w.na0;
        r.a_after_round1 = w.na1;
        r.a_after_round2 = w.na2;
        r.e_after_round0 = w.ne0;
        r.e_after_round1 = w.ne1;
        r.e_after_round2 = w.ne2;
        return r;
    endfunction

endpackage

// File: hdl/sha256_three_round_precompute_top.sv
// ----------------------------------------------------------------------------
// sha256_three_round_precompute_top
// three sha-256 rounds from a midstate, returns new a and e after each round
//
//   channel   signals                            direction
//   job       job_valid, job_stall, job          request in
//   result    result_valid, result_stall, result request out
//
// one request per cycle while the chain is not held; three round cells of two stages
// the last cell's output register holds the result while result_stall is high
// result_stall holds the whole chain while result_valid is high; job_stall rises
// in the next cycle once a request is parked in a one-entry skid buffer at the input
// reset clears all valid flags, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sha256_three_round_precompute_top_macros.svh"

module sha256_three_round_precompute_top
    import sha3p_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_valid,
    output logic    job_stall,
    input  job_t    job,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic  advance;
    logic  src_valid;
    job_t  src_job;
    work_t src_work;

    logic  c0_valid;
    work_t c0_work;
    logic  c1_valid;
    work_t c1_work;
    logic  c2_valid;
    work_t c2_work;

    assign advance = !(c2_valid && result_stall);

    sha3p_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_stall (job_stall),
        .job       (job),
        .advance   (advance),
        .src_valid (src_valid),
        .src       (src_job)
    );

    assign src_work = job_to_work(src_job);

    sha3p_round_cell u_cell0
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .round_idx (ROUND_0),
        .src_valid (src_valid),
        .src       (src_work),
        .dst_valid (c0_valid),
        .dst       (c0_work)
    );

    sha3p_round_cell u_cell1
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .round_idx (ROUND_1),
        .src_valid (c0_valid),
        .src       (c0_work),
        .dst_valid (c1_valid),
        .dst       (c1_work)
    );

    sha3p_round_cell u_cell2
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .round_idx (ROUND_2),
        .src_valid (c1_valid),
        .src       (c1_work),
        .dst_valid (c2_valid),
        .dst       (c2_work)
    );

    assign result_valid = c2_valid;
    assign result       = work_to_result(c2_work);

    // held output freezes the chain
    `SHA3P_ASSERT_NEXT(chain_holds_on_stall, result_valid && result_stall, $stable(c0_valid))
    // skid only fills while the chain is held
    `SHA3P_ASSERT_IMPL(skid_fills_on_hold, $rose(job_stall), $past(!advance))
    // a request taken into a moving chain passes through every round cell to result_valid
    `SHA3P_ASSERT_NEXT(latency_six, job_valid && !job_stall && advance ##1 advance[*5], result_valid)

endmodule

// File: hdl/sha3p_skid.sv
// ----------------------------------------------------------------------------
// sha3p_skid
// one-entry input skid buffer, keeps the request-side stall registered
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha3p_skid
    import sha3p_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  job_valid,
    output logic  job_stall,
    input  job_t  job,
    input  logic  advance,
    output logic  src_valid,
    output job_t  src
);

    logic full_reg;
    logic full_next;
    job_t skid_reg;

    always_comb
    begin
        full_next = full_reg;
        if (full_reg && advance)
        begin
            full_next = 1'b0;
        end
        else if (!full_reg && !advance && job_valid)
        begin
            full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    // park the request while the pipeline is held
    always_ff @(posedge clk)
    begin
        if (!full_reg && !advance && job_valid)
        begin
            skid_reg <= job;
        end
    end

    assign job_stall = full_reg;
    assign src_valid = full_reg | job_valid;
    assign src       = full_reg ? skid_reg : job;

endmodule

// File: hdl/sha3p_round_cell.sv
// ----------------------------------------------------------------------------
// sha3p_round_cell
// one compression round in two register stages, passes work to the next cell
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha3p_round_cell
    import sha3p_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  round_idx_t round_idx,
    input  logic       src_valid,
    input  work_t      src,
    output logic       dst_valid,
    output work_t      dst
);

    logic  mid_valid_reg;
    work_t mid_reg;
    word_t s1ch_reg;
    word_t hkw_reg;
    word_t t2_reg;

    logic  dst_valid_reg;
    work_t dst_reg;

    word_t w_sel;
    word_t s1ch_next;
    word_t hkw_next;
    word_t t2_next;
    word_t t1;
    word_t new_a;
    word_t new_e;
    work_t dst_next;

    always_comb
    begin
        case (round_idx)
            ROUND_0: w_sel = src.w0;
            ROUND_1: w_sel = src.w1;
            ROUND_2: w_sel = src.w2;
            default: w_sel = src.w0;
        endcase
    end

    // first half: partial sums of t1 and all of t2
    assign s1ch_next = big_sigma1(src.e) + choose(src.e, src.f, src.g);
    assign hkw_next  = src.h + round_k(round_idx) + w_sel;
    assign t2_next   = big_sigma0(src.a) + majority(src.a, src.b, src.c);

    // second half: finish the round and shift the working variables
    assign t1    = s1ch_reg + hkw_reg;
    assign new_a = t1 + t2_reg;
    assign new_e = mid_reg.d + t1;

    always_comb
    begin
        dst_next   = mid_reg;
        dst_next.h = mid_reg.g;
        dst_next.g = mid_reg.f;
        dst_next.f = mid_reg.e;
        dst_next.e = new_e;
        dst_next.d = mid_reg.c;
        dst_next.c = mid_reg.b;
        dst_next.b = mid_reg.a;
        dst_next.a = new_a;
        case (round_idx)
            ROUND_0:
            begin
                dst_next.na0 = new_a;
                dst_next.ne0 = new_e;
            end
            ROUND_1:
            begin
                dst_next.na1 = new_a;
                dst_next.ne1 = new_e;
            end
            ROUND_2:
            begin
                dst_next.na2 = new_a;
                dst_next.ne2 = new_e;
            end
            default:
            begin
                dst_next.na0 = new_a;
                dst_next.ne0 = new_e;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            dst_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            mid_valid_reg <= src_valid;
            dst_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mid_reg  <= src;
            s1ch_reg <= s1ch_next;
            hkw_reg  <= hkw_next;
            t2_reg   <= t2_next;
            dst_reg  <= dst_next;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst       = dst_reg;

endmodule
